// ===== hdl/edge_scroll_viewport_panner_macros.svh =====
// Assertion macros for the edge scroll viewport panner checker.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef EDGE_SCROLL_VIEWPORT_PANNER_MACROS_SVH
`define EDGE_SCROLL_VIEWPORT_PANNER_MACROS_SVH

// same-cycle implication, disabled in reset
`define ESVP_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("esvp assertion failed");

// next-cycle implication, disabled in reset
`define ESVP_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("esvp assertion failed");

`endif

// ===== hdl/esvp_pkg.sv =====
// Shared widths, codes, microcode ROM and types of the viewport panner.
// No dependencies; every other file but the macro header refers to it by scoped names.
package esvp_pkg;

  localparam int PosW    = 16;
  localparam int ScrW    = 12;
  localparam int RelW    = 12;
  localparam int DtW     = 8;
  localparam int EdgeW   = 8;
  localparam int LimW    = 16;
  localparam int MsW     = 10;
  localparam int AccW    = 10;
  localparam int SpdW    = 11;
  localparam int ViewW   = 16;
  localparam int WorldW  = 17;
  localparam int AprW    = AccW + DtW;
  localparam int NsW     = AprW + 2;
  localparam int ProdW   = SpdW + DtW + 1;
  localparam int SumW    = ((PosW > ProdW) ? PosW : ProdW) + 2;
  localparam int AddrW   = 5;
  localparam int DataW   = 32;
  localparam int StepW   = 3;

  localparam logic [EdgeW-1:0] RstEdgeGap    = 8'd5;
  localparam logic [ScrW-1:0]  RstRightEdgeX = 12'd619;
  localparam logic [ScrW-1:0]  RstBottomEdgeY = 12'd339;
  localparam logic [LimW-1:0]  RstMaxPosX    = 16'd640;
  localparam logic [LimW-1:0]  RstMaxPosY    = 16'd920;
  localparam logic [MsW-1:0]   RstMaxSpeed   = 10'd40;
  localparam logic [AccW-1:0]  RstAccelStep  = 10'd7;

  typedef enum logic [1:0] {
    ACT_MOVE   = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_LCLICK = 2'd2,
    ACT_RCLICK = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SELECT = 2'd1,
    EV_MOVE   = 2'd2
  } event_e;

  typedef enum logic [2:0] {
    REG_EDGE_GAP   = 3'd0,
    REG_RIGHT_X    = 3'd1,
    REG_BOTTOM_Y   = 3'd2,
    REG_MAX_POS_X  = 3'd3,
    REG_MAX_POS_Y  = 3'd4,
    REG_MAX_SPEED  = 3'd5,
    REG_ACCEL_STEP = 3'd6
  } reg_idx_e;

  typedef enum logic [2:0] {
    UOP_NOP   = 3'd0,
    UOP_DIR   = 3'd1,
    UOP_MULA  = 3'd2,
    UOP_SPD   = 3'd3,
    UOP_MULP  = 3'd4,
    UOP_POS   = 3'd5,
    UOP_WORLD = 3'd6
  } uop_e;

  typedef enum logic [1:0] {
    BR_NEXT   = 2'd0,
    BR_ACTION = 2'd1,
    BR_DONE   = 2'd2
  } br_e;

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'b01,
    SEQ_RUN  = 2'b10
  } seq_state_e;

  localparam logic [StepW-1:0] StepDisp  = 3'd0;
  localparam logic [StepW-1:0] StepDir   = 3'd1;
  localparam logic [StepW-1:0] StepMulA  = 3'd2;
  localparam logic [StepW-1:0] StepSpd   = 3'd3;
  localparam logic [StepW-1:0] StepMulP  = 3'd4;
  localparam logic [StepW-1:0] StepPos   = 3'd5;
  localparam logic [StepW-1:0] StepWorld = 3'd6;

  typedef struct packed {
    uop_e uop;
    br_e  br;
  } ucw_t;

  typedef struct packed {
    logic load;
    logic en;
    logic last;
    uop_e uop;
  } ctrl_t;

  typedef struct packed {
    logic [EdgeW-1:0] edge_gap;
    logic [ScrW-1:0]  right_edge_x;
    logic [ScrW-1:0]  bottom_edge_y;
    logic [LimW-1:0]  max_pos_x;
    logic [LimW-1:0]  max_pos_y;
    logic [MsW-1:0]   max_speed;
    logic [AccW-1:0]  accel_step;
  } cfg_t;

  function automatic ucw_t ucode(input logic [StepW-1:0] step);
    ucw_t w;
    unique case (step)
      StepDisp:  w = '{uop: UOP_NOP,   br: BR_ACTION};
      StepDir:   w = '{uop: UOP_DIR,   br: BR_DONE};
      StepMulA:  w = '{uop: UOP_MULA,  br: BR_NEXT};
      StepSpd:   w = '{uop: UOP_SPD,   br: BR_NEXT};
      StepMulP:  w = '{uop: UOP_MULP,  br: BR_NEXT};
      StepPos:   w = '{uop: UOP_POS,   br: BR_DONE};
      StepWorld: w = '{uop: UOP_WORLD, br: BR_DONE};
      default:   w = '{uop: UOP_NOP,   br: BR_DONE};
    endcase
    return w;
  endfunction

  function automatic logic [StepW-1:0] entry_of(input action_e act);
    logic [StepW-1:0] s;
    unique case (act)
      ACT_MOVE:   s = StepDir;
      ACT_TICK:   s = StepMulA;
      ACT_LCLICK: s = StepWorld;
      ACT_RCLICK: s = StepWorld;
      default:    s = StepWorld;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/esvp_cfg_regs.sv =====
// APB register file of the viewport panner: edge bands, limits, speed, ramp.
// Depends on esvp_pkg.
module esvp_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [esvp_pkg::AddrW-1:0]  paddr,
  input  logic [esvp_pkg::DataW-1:0]  pwdata,
  output logic [esvp_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output esvp_pkg::cfg_t              cfg_o
);

  esvp_pkg::cfg_t     cfg_q, cfg_d;
  esvp_pkg::reg_idx_e idx;
  logic               wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = esvp_pkg::reg_idx_e'(paddr[esvp_pkg::AddrW-1:2]);
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        esvp_pkg::REG_EDGE_GAP:   cfg_d.edge_gap      = pwdata[esvp_pkg::EdgeW-1:0];
        esvp_pkg::REG_RIGHT_X:    cfg_d.right_edge_x  = pwdata[esvp_pkg::ScrW-1:0];
        esvp_pkg::REG_BOTTOM_Y:   cfg_d.bottom_edge_y = pwdata[esvp_pkg::ScrW-1:0];
        esvp_pkg::REG_MAX_POS_X:  cfg_d.max_pos_x     = pwdata[esvp_pkg::LimW-1:0];
        esvp_pkg::REG_MAX_POS_Y:  cfg_d.max_pos_y     = pwdata[esvp_pkg::LimW-1:0];
        esvp_pkg::REG_MAX_SPEED:  cfg_d.max_speed     = pwdata[esvp_pkg::MsW-1:0];
        esvp_pkg::REG_ACCEL_STEP: cfg_d.accel_step    = pwdata[esvp_pkg::AccW-1:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      esvp_pkg::REG_EDGE_GAP:   prdata = esvp_pkg::DataW'(cfg_q.edge_gap);
      esvp_pkg::REG_RIGHT_X:    prdata = esvp_pkg::DataW'(cfg_q.right_edge_x);
      esvp_pkg::REG_BOTTOM_Y:   prdata = esvp_pkg::DataW'(cfg_q.bottom_edge_y);
      esvp_pkg::REG_MAX_POS_X:  prdata = esvp_pkg::DataW'(cfg_q.max_pos_x);
      esvp_pkg::REG_MAX_POS_Y:  prdata = esvp_pkg::DataW'(cfg_q.max_pos_y);
      esvp_pkg::REG_MAX_SPEED:  prdata = esvp_pkg::DataW'(cfg_q.max_speed);
      esvp_pkg::REG_ACCEL_STEP: prdata = esvp_pkg::DataW'(cfg_q.accel_step);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.edge_gap      <= esvp_pkg::RstEdgeGap;
      cfg_q.right_edge_x  <= esvp_pkg::RstRightEdgeX;
      cfg_q.bottom_edge_y <= esvp_pkg::RstBottomEdgeY;
      cfg_q.max_pos_x     <= esvp_pkg::RstMaxPosX;
      cfg_q.max_pos_y     <= esvp_pkg::RstMaxPosY;
      cfg_q.max_speed     <= esvp_pkg::RstMaxSpeed;
      cfg_q.accel_step    <= esvp_pkg::RstAccelStep;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== hdl/esvp_sequencer.sv =====
// Microcode sequencer: step counter, ROM fetch, dispatch on action, result valid.
// Depends on esvp_pkg for the ROM, codes and control word types.
module esvp_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  esvp_pkg::action_e act_i,
  output esvp_pkg::ctrl_t   ctrl_o
);

  esvp_pkg::seq_state_e           state_q, state_d;
  logic [esvp_pkg::StepW-1:0]     step_q, step_d;
  logic                           out_valid_q, out_valid_d;
  esvp_pkg::ucw_t                 cw;
  logic                           hold;
  logic                           en;

  assign cw   = esvp_pkg::ucode(step_q);
  // hold the final step while the result register is still full and stalled
  assign hold = (cw.br == esvp_pkg::BR_DONE) && out_valid_q && out_stall_i;
  assign en   = (state_q == esvp_pkg::SEQ_RUN) && !hold;

  assign in_stall_o  = (state_q != esvp_pkg::SEQ_IDLE);
  assign out_valid_o = out_valid_q;

  assign ctrl_o.load = (state_q == esvp_pkg::SEQ_IDLE) && in_valid_i;
  assign ctrl_o.en   = en;
  assign ctrl_o.last = (cw.br == esvp_pkg::BR_DONE);
  assign ctrl_o.uop  = cw.uop;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      esvp_pkg::SEQ_IDLE: begin
        if (in_valid_i) begin
          state_d = esvp_pkg::SEQ_RUN;
          step_d  = esvp_pkg::StepDisp;
        end
      end
      esvp_pkg::SEQ_RUN: begin
        if (en) begin
          unique case (cw.br)
            esvp_pkg::BR_NEXT:   step_d = esvp_pkg::StepW'(step_q + 1'b1);
            esvp_pkg::BR_ACTION: step_d = esvp_pkg::entry_of(act_i);
            esvp_pkg::BR_DONE: begin
              state_d     = esvp_pkg::SEQ_IDLE;
              out_valid_d = 1'b1;
            end
            default: state_d = esvp_pkg::SEQ_IDLE;
          endcase
        end
      end
      default: state_d = esvp_pkg::SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= esvp_pkg::SEQ_IDLE;
      step_q      <= esvp_pkg::StepDisp;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hdl/esvp_datapath.sv =====
// Datapath of the viewport panner: item latch, direction, speed ramp,
// position clamp, world coordinate and result register. Depends on esvp_pkg.
module esvp_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  esvp_pkg::ctrl_t                   ctrl_i,
  input  esvp_pkg::cfg_t                    cfg_i,
  input  logic [1:0]                        action_i,
  input  logic [esvp_pkg::ScrW-1:0]         mouse_x_i,
  input  logic [esvp_pkg::ScrW-1:0]         mouse_y_i,
  input  logic signed [esvp_pkg::RelW-1:0]  rel_x_i,
  input  logic signed [esvp_pkg::RelW-1:0]  rel_y_i,
  input  logic [esvp_pkg::DtW-1:0]          delta_i,
  output esvp_pkg::action_e                 act_o,
  output logic [esvp_pkg::ViewW-1:0]        view_x_o,
  output logic [esvp_pkg::ViewW-1:0]        view_y_o,
  output logic [esvp_pkg::WorldW-1:0]       world_x_o,
  output logic [esvp_pkg::WorldW-1:0]       world_y_o,
  output logic [1:0]                        event_res_o
);

  localparam int PosW  = esvp_pkg::PosW;
  localparam int SpdW  = esvp_pkg::SpdW;
  localparam int AprW  = esvp_pkg::AprW;
  localparam int NsW   = esvp_pkg::NsW;
  localparam int ProdW = esvp_pkg::ProdW;
  localparam int SumW  = esvp_pkg::SumW;
  localparam int ViewW = esvp_pkg::ViewW;
  localparam int WldW  = esvp_pkg::WorldW;
  localparam int ScrW  = esvp_pkg::ScrW;

  function automatic logic signed [1:0] pick_dir(
    input logic [ScrW-1:0]                  m,
    input logic signed [esvp_pkg::RelW-1:0] rel,
    input logic [esvp_pkg::EdgeW-1:0]       low_band,
    input logic [ScrW-1:0]                  high_band
  );
    logic signed [1:0] d;
    if ((m <= ScrW'(low_band)) && (rel <= 0)) begin
      d = 2'sb11;
    end else if ((m >= high_band) && (rel >= 0)) begin
      d = 2'sb01;
    end else begin
      d = 2'sb00;
    end
    return d;
  endfunction

  function automatic logic signed [SpdW-1:0] spd_next(
    input logic signed [SpdW-1:0]    spd,
    input logic signed [1:0]         dir,
    input logic [esvp_pkg::MsW-1:0]  ms,
    input logic [AprW-1:0]           apr,
    input logic                      acc_nz
  );
    logic signed [NsW-1:0] s, t, m, a, sum, r;
    logic                  neg, went_neg, snap;
    s = NsW'(spd);
    m = NsW'(ms);
    a = NsW'(apr);
    priority if (dir == 2'sb01) begin
      t = m;
    end else if (dir == 2'sb11) begin
      t = -m;
    end else begin
      t = '0;
    end
    neg = (t < s);
    priority if (s == t) begin
      sum = s;
    end else if (neg) begin
      sum = s - a;
    end else begin
      sum = s + a;
    end
    went_neg = (s != t) && neg && acc_nz;
    // snap to the target when the ramp overshoots it, or on a downward ramp when accel_step is zero
    snap = (sum != t) && ((t < sum) != went_neg);
    r    = snap ? t : sum;
    return r[SpdW-1:0];
  endfunction

  function automatic logic [PosW-1:0] pos_next(
    input logic [PosW-1:0]           pos,
    input logic signed [ProdW-1:0]   prod,
    input logic [esvp_pkg::LimW-1:0] limit
  );
    logic signed [SumW-1:0] p, lim, top;
    top           = '0;
    top[PosW-1:0] = '1;
    lim           = SumW'(limit);
    if (top < lim) begin
      lim = top;
    end
    p = SumW'(pos) + SumW'(prod);
    if (p > lim) begin
      p = lim;
    end
    if (p < 0) begin
      p = '0;
    end
    return p[PosW-1:0];
  endfunction

  function automatic logic [ViewW-1:0] view_of(input logic [PosW-1:0] pos);
    logic [ViewW+PosW-1:0] e;
    e = (ViewW + PosW)'(pos);
    return e[ViewW-1:0];
  endfunction

  function automatic logic [WldW-1:0] world_of(
    input logic [ScrW-1:0] m,
    input logic [PosW-1:0] pos
  );
    logic [WldW+PosW-1:0] e;
    e = (WldW + PosW)'(pos);
    return WldW'(e[WldW-1:0] + WldW'(m));
  endfunction

  esvp_pkg::action_e            act_q;
  logic [ScrW-1:0]              mx_q, my_q;
  logic signed [esvp_pkg::RelW-1:0] rx_q, ry_q;
  logic [esvp_pkg::DtW-1:0]     dt_q;

  logic [PosW-1:0]              pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic signed [SpdW-1:0]       spd_x_q, spd_x_d, spd_y_q, spd_y_d;
  logic signed [1:0]            dir_x_q, dir_x_d, dir_y_q, dir_y_d;
  logic [AprW-1:0]              apr_q, apr_d;
  logic signed [ProdW-1:0]      prod_x_q, prod_x_d, prod_y_q, prod_y_d;

  logic [ViewW-1:0]             view_x_q, view_y_q;
  logic [WldW-1:0]              world_x_q, world_x_d, world_y_q, world_y_d;
  esvp_pkg::event_e             ev_q, ev_d;

  always_comb begin
    pos_x_d  = pos_x_q;
    pos_y_d  = pos_y_q;
    spd_x_d  = spd_x_q;
    spd_y_d  = spd_y_q;
    dir_x_d  = dir_x_q;
    dir_y_d  = dir_y_q;
    apr_d    = apr_q;
    prod_x_d = prod_x_q;
    prod_y_d = prod_y_q;
    if (ctrl_i.en) begin
      unique case (ctrl_i.uop)
        esvp_pkg::UOP_DIR: begin
          dir_x_d = pick_dir(mx_q, rx_q, cfg_i.edge_gap, cfg_i.right_edge_x);
          dir_y_d = pick_dir(my_q, ry_q, cfg_i.edge_gap, cfg_i.bottom_edge_y);
        end
        esvp_pkg::UOP_MULA: begin
          apr_d = AprW'(cfg_i.accel_step) * AprW'(dt_q);
        end
        esvp_pkg::UOP_SPD: begin
          spd_x_d = spd_next(spd_x_q, dir_x_q, cfg_i.max_speed, apr_q,
                             |cfg_i.accel_step);
          spd_y_d = spd_next(spd_y_q, dir_y_q, cfg_i.max_speed, apr_q,
                             |cfg_i.accel_step);
        end
        esvp_pkg::UOP_MULP: begin
          prod_x_d = ProdW'(spd_x_q) * ProdW'($signed({1'b0, dt_q}));
          prod_y_d = ProdW'(spd_y_q) * ProdW'($signed({1'b0, dt_q}));
        end
        esvp_pkg::UOP_POS: begin
          pos_x_d = pos_next(pos_x_q, prod_x_q, cfg_i.max_pos_x);
          pos_y_d = pos_next(pos_y_q, prod_y_q, cfg_i.max_pos_y);
        end
        default: begin
          pos_x_d = pos_x_q;
        end
      endcase
    end
  end

  always_comb begin
    if (ctrl_i.uop == esvp_pkg::UOP_WORLD) begin
      world_x_d = world_of(mx_q, pos_x_q);
      world_y_d = world_of(my_q, pos_y_q);
      ev_d      = (act_q == esvp_pkg::ACT_RCLICK) ? esvp_pkg::EV_MOVE : esvp_pkg::EV_SELECT;
    end else begin
      world_x_d = '0;
      world_y_d = '0;
      ev_d      = esvp_pkg::EV_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      spd_x_q <= '0;
      spd_y_q <= '0;
      dir_x_q <= '0;
      dir_y_q <= '0;
    end else begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      spd_x_q <= spd_x_d;
      spd_y_q <= spd_y_d;
      dir_x_q <= dir_x_d;
      dir_y_q <= dir_y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    apr_q    <= apr_d;
    prod_x_q <= prod_x_d;
    prod_y_q <= prod_y_d;
    if (ctrl_i.load) begin
      act_q <= esvp_pkg::action_e'(action_i);
      mx_q  <= mouse_x_i;
      my_q  <= mouse_y_i;
      rx_q  <= rel_x_i;
      ry_q  <= rel_y_i;
      dt_q  <= delta_i;
    end
    if (ctrl_i.en && ctrl_i.last) begin
      view_x_q  <= view_of(pos_x_d);
      view_y_q  <= view_of(pos_y_d);
      world_x_q <= world_x_d;
      world_y_q <= world_y_d;
      ev_q      <= ev_d;
    end
  end

  assign act_o       = act_q;
  assign view_x_o    = view_x_q;
  assign view_y_o    = view_y_q;
  assign world_x_o   = world_x_q;
  assign world_y_o   = world_y_q;
  assign event_res_o = ev_q;

endmodule

// ===== hdl/edge_scroll_viewport_panner.sv =====
// Top level of the edge scroll viewport panner.
// Depends on esvp_pkg, esvp_cfg_regs, esvp_sequencer and esvp_datapath.
//
//   port group   handshake                  payload
//   input item   in_valid_i / in_stall_o    action, mouse_x/y, rel_x/y, delta
//   result item  out_valid_o / out_stall_i  view_x/y, world_x/y, event_res
//   config       APB psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// One microcode step per cycle while the final step is not held. Pointer moves and
// clicks run the dispatch plus one step between acceptances; ticks run the
// dispatch plus four steps. The microprogram length sets these step counts.
// Reset loads the register defaults and clears position, speed and direction.
// The final step holds while a previous result is still stalled at the output.
module edge_scroll_viewport_panner (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        action_i,
  input  logic [esvp_pkg::ScrW-1:0]         mouse_x_i,
  input  logic [esvp_pkg::ScrW-1:0]         mouse_y_i,
  input  logic signed [esvp_pkg::RelW-1:0]  rel_x_i,
  input  logic signed [esvp_pkg::RelW-1:0]  rel_y_i,
  input  logic [esvp_pkg::DtW-1:0]          delta_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [esvp_pkg::ViewW-1:0]        view_x_o,
  output logic [esvp_pkg::ViewW-1:0]        view_y_o,
  output logic [esvp_pkg::WorldW-1:0]       world_x_o,
  output logic [esvp_pkg::WorldW-1:0]       world_y_o,
  output logic [1:0]                        event_res_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [esvp_pkg::AddrW-1:0]        paddr,
  input  logic [esvp_pkg::DataW-1:0]        pwdata,
  output logic [esvp_pkg::DataW-1:0]        prdata,
  output logic                              pready
);

  esvp_pkg::cfg_t    cfg;
  esvp_pkg::ctrl_t   ctrl;
  esvp_pkg::action_e act;

  esvp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  esvp_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .act_i       (act),
    .ctrl_o      (ctrl)
  );

  esvp_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cfg_i       (cfg),
    .action_i    (action_i),
    .mouse_x_i   (mouse_x_i),
    .mouse_y_i   (mouse_y_i),
    .rel_x_i     (rel_x_i),
    .rel_y_i     (rel_y_i),
    .delta_i     (delta_i),
    .act_o       (act),
    .view_x_o    (view_x_o),
    .view_y_o    (view_y_o),
    .world_x_o   (world_x_o),
    .world_y_o   (world_y_o),
    .event_res_o (event_res_o)
  );

endmodule

// ===== hdl/esvp_checker.sv =====
// Port-level checker for the viewport panner, bound to the top level.
// Depends on esvp_pkg and edge_scroll_viewport_panner_macros.svh.
`include "edge_scroll_viewport_panner_macros.svh"

module esvp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [esvp_pkg::ViewW-1:0]   view_x_o,
  input logic [esvp_pkg::ViewW-1:0]   view_y_o,
  input logic [esvp_pkg::WorldW-1:0]  world_x_o,
  input logic [esvp_pkg::WorldW-1:0]  world_y_o,
  input logic [1:0]                   event_res_o
);

  `ESVP_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(view_x_o) && $stable(view_y_o) && $stable(world_x_o) && $stable(world_y_o) && $stable(event_res_o))
  `ESVP_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `ESVP_ASSERT_IMP(a_done_frees_input, $rose(out_valid_o), !in_stall_o)
  `ESVP_ASSERT_IMP(a_world_zero, out_valid_o && (event_res_o == esvp_pkg::EV_NONE), (world_x_o == '0) && (world_y_o == '0))

endmodule

bind edge_scroll_viewport_panner esvp_checker u_esvp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .view_x_o    (view_x_o),
  .view_y_o    (view_y_o),
  .world_x_o   (world_x_o),
  .world_y_o   (world_y_o),
  .event_res_o (event_res_o)
);
